FILE: rtl/cmf_pkg.sv
// shared types and constants for the cosmic ray mask filter
// depends on nothing; every other rtl file refers to it by scoped names
package cmf_pkg;

   // threshold register
   localparam int CLIP_BITS = 16;
   localparam logic [CLIP_BITS-1:0] CLIP_RESET = 16'd1280;

   // width of the hit count shown on the result channel
   localparam int HIT_COUNT_BITS = 16;

   // window geometry
   localparam int TAPS = 5;
   localparam int WINDOW_DEPTH = 4;
   localparam int SIGMA_DEPTH = 2;

   // samples seen in the current spectrum, saturating
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_TWO = 2'd2;
   localparam logic [1:0] SEEN_MAX = 2'd3;

   // tail flush sequencer
   typedef enum logic [1:0] {
      FLUSH_IDLE,
      FLUSH_TAIL,
      FLUSH_LAST
   } flush_state_type;

   // control that travels with a window job
   typedef struct packed {
      logic valid;
      logic last;
   } job_ctrl_type;

   // detection result handed to the output stage
   typedef struct packed {
      logic valid;
      logic hit;
      logic last;
   } hit_info_type;

   // result transaction payload
   typedef struct packed {
      logic                      is_cosmic;
      logic [HIT_COUNT_BITS-1:0] hit_count;
      logic                      last_result;
   } result_type;

endpackage

FILE: rtl/cmf_if.sv
// channel interfaces of the cosmic ray mask filter: sample input, result output,
// threshold register write; depends on cmf_pkg

// sample channel
interface cmf_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] flux_sample;
   logic signed [SAMPLE_BITS-1:0] sigma_sample;
   logic                          end_of_spectrum;

   modport source (output valid, output flux_sample, output sigma_sample,
                   output end_of_spectrum, input ready);
   modport sink (input valid, input flux_sample, input sigma_sample,
                 input end_of_spectrum, output ready);
endinterface

// result channel
interface cmf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                is_cosmic;
   logic [cmf_pkg::HIT_COUNT_BITS-1:0]  hit_count;
   logic                                last_result;

   modport source (output valid, output is_cosmic, output hit_count,
                   output last_result, input ready);
   modport sink (input valid, input is_cosmic, input hit_count,
                 input last_result, output ready);
endinterface

// threshold register write channel
interface cmf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [cmf_pkg::CLIP_BITS-1:0]  clip_factor;

   modport source (output valid, output clip_factor, input ready);
   modport sink (input valid, input clip_factor, output ready);
endinterface

FILE: rtl/cmf_window.sv
// sample window and tail flush sequencer: holds the last four fluxes and two
// pending sigmas, issues one five-tap job per advancing cycle; uses cmf_pkg
module cmf_window #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  logic signed [SAMPLE_BITS-1:0] flux_sample,
   input  logic signed [SAMPLE_BITS-1:0] sigma_sample,
   input  logic                          end_of_spectrum,
   output cmf_pkg::job_ctrl_type         job_ctrl,
   output logic signed [SAMPLE_BITS-1:0] job_taps [cmf_pkg::TAPS],
   output logic signed [SAMPLE_BITS-1:0] job_sigma
);

   logic signed [SAMPLE_BITS-1:0] win_ff [cmf_pkg::WINDOW_DEPTH];
   logic signed [SAMPLE_BITS-1:0] win_in [cmf_pkg::WINDOW_DEPTH];
   logic signed [SAMPLE_BITS-1:0] eff    [cmf_pkg::WINDOW_DEPTH];
   logic signed [SAMPLE_BITS-1:0] sigma_ff [cmf_pkg::SIGMA_DEPTH];
   logic signed [SAMPLE_BITS-1:0] sigma_in [cmf_pkg::SIGMA_DEPTH];
   logic [1:0]                    seen_ff;
   logic [1:0]                    seen_in;
   cmf_pkg::flush_state_type      state_ff;
   cmf_pkg::flush_state_type      state_in;
   cmf_pkg::job_ctrl_type         ctrl_ff;
   cmf_pkg::job_ctrl_type         ctrl_in;
   logic signed [SAMPLE_BITS-1:0] taps_ff [cmf_pkg::TAPS];
   logic signed [SAMPLE_BITS-1:0] taps_in [cmf_pkg::TAPS];
   logic signed [SAMPLE_BITS-1:0] jsig_ff;
   logic signed [SAMPLE_BITS-1:0] jsig_in;
   logic                          accept;

   // new samples only while no tail flush is running
   assign item_ready = advance && (state_ff == cmf_pkg::FLUSH_IDLE);
   assign accept     = item_valid && item_ready;

   // first sample of a spectrum fills the whole window (left edge clamp)
   always_comb begin
      for (int i = 0; i < cmf_pkg::WINDOW_DEPTH; i++) begin
         eff[i] = (seen_ff == cmf_pkg::SEEN_NONE) ? flux_sample : win_ff[i];
      end
   end

   // next state, window shift and job issue
   always_comb begin
      win_in   = win_ff;
      sigma_in = sigma_ff;
      seen_in  = seen_ff;
      state_in = state_ff;
      ctrl_in  = ctrl_ff;
      taps_in  = taps_ff;
      jsig_in  = jsig_ff;
      if (advance) begin
         ctrl_in.valid = 1'b0;
         ctrl_in.last  = 1'b0;
         case (state_ff)
            cmf_pkg::FLUSH_IDLE: begin
               if (accept) begin
                  // center sample two back now has both right neighbors
                  if (seen_ff >= cmf_pkg::SEEN_TWO) begin
                     ctrl_in.valid = 1'b1;
                     taps_in = '{eff[0], eff[1], eff[2], eff[3], flux_sample};
                     jsig_in = sigma_ff[0];
                  end
                  win_in   = '{eff[1], eff[2], eff[3], flux_sample};
                  sigma_in = '{sigma_ff[1], sigma_sample};
                  if (end_of_spectrum) begin
                     state_in = (seen_ff != cmf_pkg::SEEN_NONE) ?
                                cmf_pkg::FLUSH_TAIL : cmf_pkg::FLUSH_LAST;
                  end else if (seen_ff != cmf_pkg::SEEN_MAX) begin
                     seen_in = seen_ff + 2'd1;
                  end
               end
            end
            cmf_pkg::FLUSH_TAIL: begin
               // second to last sample, right edge clamped once
               ctrl_in.valid = 1'b1;
               taps_in  = '{win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[3]};
               jsig_in  = sigma_ff[0];
               state_in = cmf_pkg::FLUSH_LAST;
            end
            cmf_pkg::FLUSH_LAST: begin
               // final sample, right edge clamped twice
               ctrl_in.valid = 1'b1;
               ctrl_in.last  = 1'b1;
               taps_in  = '{win_ff[1], win_ff[2], win_ff[3], win_ff[3], win_ff[3]};
               jsig_in  = sigma_ff[1];
               seen_in  = cmf_pkg::SEEN_NONE;
               state_in = cmf_pkg::FLUSH_IDLE;
            end
            default: begin
               state_in = cmf_pkg::FLUSH_IDLE;
            end
         endcase
      end
   end

   // flush sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmf_pkg::FLUSH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= cmf_pkg::SEEN_NONE;
         ctrl_ff <= '0;
      end else begin
         seen_ff <= seen_in;
         ctrl_ff <= ctrl_in;
      end
   end

   // window and job payload
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      sigma_ff <= sigma_in;
      taps_ff  <= taps_in;
      jsig_ff  <= jsig_in;
   end

   assign job_ctrl  = ctrl_ff;
   assign job_taps  = taps_ff;
   assign job_sigma = jsig_ff;

endmodule

FILE: rtl/cmf_detect.sv
// high-pass response, threshold product and compare for one window job
// depends on cmf_pkg
module cmf_detect #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [cmf_pkg::CLIP_BITS-1:0]   clip_factor,
   input  cmf_pkg::job_ctrl_type           job_ctrl,
   input  logic signed [SAMPLE_BITS-1:0]   job_taps [cmf_pkg::TAPS],
   input  logic signed [SAMPLE_BITS-1:0]   job_sigma,
   output cmf_pkg::hit_info_type           hit_info
);

   localparam int EXT_BITS  = 5;
   localparam int RESP_BITS = SAMPLE_BITS + EXT_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + cmf_pkg::CLIP_BITS + 1;
   localparam int CMP_BITS  = PROD_BITS + 1;

   logic signed [RESP_BITS-1:0] tap_ext [cmf_pkg::TAPS];
   logic signed [RESP_BITS-1:0] resp;
   logic signed [PROD_BITS-1:0] prod;
   logic                        sigma_pos;
   logic signed [RESP_BITS-1:0] resp_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                        sigma_pos_ff;
   cmf_pkg::job_ctrl_type       ctrl_ff;
   logic signed [CMP_BITS-1:0]  resp_scaled;
   logic signed [CMP_BITS-1:0]  prod_wide;

   // response times 16: 10*c - 4*(l1+r1) - (l2+r2)
   always_comb begin
      for (int i = 0; i < cmf_pkg::TAPS; i++) begin
         tap_ext[i] = {{EXT_BITS{job_taps[i][SAMPLE_BITS-1]}}, job_taps[i]};
      end
      resp = (tap_ext[2] <<< 3) + (tap_ext[2] <<< 1)
             - ((tap_ext[1] + tap_ext[3]) <<< 2)
             - (tap_ext[0] + tap_ext[4]);
   end

   // threshold: clip (8 fraction bits) times sigma
   assign prod      = $signed({1'b0, clip_factor}) * job_sigma;
   assign sigma_pos = !job_sigma[SAMPLE_BITS-1] && (job_sigma != '0);

   // compute stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= job_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         resp_ff      <= resp;
         prod_ff      <= prod;
         sigma_pos_ff <= sigma_pos;
      end
   end

   // exact compare 16*resp16 > clip*sigma
   assign resp_scaled = {{(CMP_BITS - RESP_BITS - 4){resp_ff[RESP_BITS-1]}}, resp_ff, 4'b0000};
   assign prod_wide   = {{(CMP_BITS - PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};

   always_comb begin
      hit_info.valid = ctrl_ff.valid;
      hit_info.last  = ctrl_ff.last;
      hit_info.hit   = sigma_pos_ff && (resp_scaled > prod_wide);
   end

endmodule

FILE: rtl/cmf_out.sv
// saturating hit counter, result register and skid stage; drives the stall
// of the upstream stages; depends on cmf_pkg
module cmf_out #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmf_pkg::hit_info_type hit_info,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cmf_pkg::result_type   result
);

   localparam int HIT_BITS = cmf_pkg::HIT_COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_next;
   logic                  take;
   cmf_pkg::result_type   new_result;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   cmf_pkg::result_type   out_ff;
   cmf_pkg::result_type   out_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   cmf_pkg::result_type   skid_ff;
   cmf_pkg::result_type   skid_in;

   // pipeline moves whenever the skid stage is free
   assign advance = !skid_valid_ff;
   assign take    = hit_info.valid && advance;

   // saturating count, cleared after the final sample of a spectrum
   always_comb begin
      count_next = (hit_info.hit && (count_ff != COUNT_MAX)) ? count_ff + 1'b1 : count_ff;
      new_result.is_cosmic   = hit_info.hit;
      new_result.hit_count   = HIT_BITS'(count_next);
      new_result.last_result = hit_info.last;
      count_in = count_ff;
      if (take) begin
         count_in = hit_info.last ? '0 : count_next;
      end
   end

   // result register with skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !rsp_ready) begin
         if (take) begin
            skid_valid_in = 1'b1;
            skid_in       = new_result;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = take;
         out_in       = new_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

endmodule

FILE: rtl/cosmic_ray_mask_filter.sv
// cosmic ray mask filter top level: window, detect and output stages
// depends on cmf_pkg, cmf_if, cmf_window, cmf_detect, cmf_out
// path: a sample's result is formed after the sample two positions later is
// accepted (final samples: in the flush) via job, detect and output registers
// throughput: one sample per cycle unless stalled; the flush after the final
// sample (tail and last states; last only in a one-sample spectrum) takes none
// reset: synchronous, clears control state, clip_factor returns to 1280
module cosmic_ray_mask_filter #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input logic         clock,
   input logic         reset,
   cmf_req_if.sink     req_chan,
   cmf_rsp_if.source   rsp_chan,
   cmf_csr_if.sink     csr_chan
);

   logic [cmf_pkg::CLIP_BITS-1:0]  clip_ff;
   logic                           advance;
   cmf_pkg::job_ctrl_type          job_ctrl;
   logic signed [SAMPLE_BITS-1:0]  job_taps [cmf_pkg::TAPS];
   logic signed [SAMPLE_BITS-1:0]  job_sigma;
   cmf_pkg::hit_info_type          hit_info;
   cmf_pkg::result_type            result;

   // threshold register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= cmf_pkg::CLIP_RESET;
      end else if (csr_chan.valid) begin
         clip_ff <= csr_chan.clip_factor;
      end
   end

   // window and flush sequencer
   cmf_window #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .item_valid      (req_chan.valid),
      .item_ready      (req_chan.ready),
      .flux_sample     (req_chan.flux_sample),
      .sigma_sample    (req_chan.sigma_sample),
      .end_of_spectrum (req_chan.end_of_spectrum),
      .job_ctrl        (job_ctrl),
      .job_taps        (job_taps),
      .job_sigma       (job_sigma)
   );

   // response and threshold compare
   cmf_detect #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_detect (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .clip_factor (clip_ff),
      .job_ctrl    (job_ctrl),
      .job_taps    (job_taps),
      .job_sigma   (job_sigma),
      .hit_info    (hit_info)
   );

   // hit count and result register
   cmf_out #(
      .COUNT_BITS (COUNT_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .hit_info  (hit_info),
      .advance   (advance),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .result    (result)
   );

   assign rsp_chan.is_cosmic   = result.is_cosmic;
   assign rsp_chan.hit_count   = result.hit_count;
   assign rsp_chan.last_result = result.last_result;

endmodule

FILE: rtl/cmf_checker.sv
// port-level checks for the cosmic ray mask filter, bound to the top level
// depends on cmf_pkg and cosmic_ray_mask_filter
module cmf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_end,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_is_cosmic,
   input logic [cmf_pkg::HIT_COUNT_BITS-1:0] rsp_hit_count,
   input logic                               rsp_last
);

   // out of reset: no result pending, samples taken
   assert property (@(posedge clock) $past(reset) |-> (!rsp_valid && req_ready))
      else $error("cmf: bad state after reset");

   // final sample starts a flush that holds off new samples
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end) |=> !req_ready)
      else $error("cmf: sample taken during tail flush");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable({rsp_is_cosmic, rsp_hit_count, rsp_last})))
      else $error("cmf: stalled result changed");

   // count only moves on a flagged sample within a spectrum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_is_cosmic &&
       $past(rsp_valid && rsp_ready && !rsp_last)) |->
         (rsp_hit_count == $past(rsp_hit_count)))
      else $error("cmf: hit count moved without a hit");

endmodule

bind cosmic_ray_mask_filter cmf_checker u_cmf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_end       (req_chan.end_of_spectrum),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_is_cosmic (rsp_chan.is_cosmic),
   .rsp_hit_count (rsp_chan.hit_count),
   .rsp_last      (rsp_chan.last_result)
);

FILE: tb/tb_cosmic_ray_mask_filter.sv
// self-checking testbench for the cosmic ray mask filter top level
// depends on cmf_pkg, the channel interfaces in cmf_if and cosmic_ray_mask_filter
// a built-in window predictor checks every result transaction in order
`timescale 1ns / 1ps

module tb_cosmic_ray_mask_filter;

   localparam int SAMPLE_BITS = 24;
   localparam int COUNT_BITS = 16;
   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 4;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 50;
   localparam longint HIT_CEILING = (64'd1 << COUNT_BITS) - 1;
   localparam longint CENTER_GAIN = 10;
   localparam longint NEAR_GAIN = 4;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] flux;
      logic signed [SAMPLE_BITS-1:0] sigma;
      logic                          eos;
   } pixel_type;

   // flavors of random pixels
   typedef enum int {
      PIX_WILD,
      PIX_BACKGROUND,
      PIX_SPIKE,
      PIX_DEAD_SIGMA
   } pixel_kind_type;

   logic clock;
   logic reset;

   cmf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   cmf_rsp_if rsp_bus ();
   cmf_csr_if csr_bus ();

   cosmic_ray_mask_filter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // pixels waiting to be sent and results the window predicts
   pixel_type            pending_pixels[$];
   cmf_pkg::result_type  predicted_results[$];

   // predictor copy of the filter state
   logic [cmf_pkg::CLIP_BITS-1:0] clip_now = cmf_pkg::CLIP_RESET;
   longint                        flux_win[4];
   longint                        sigma_wait[2];
   int                            pixels_in_spec = 0;
   longint                        hit_tally = 0;

   // flow control between the stimulus sequence and the channel processes
   bit        steady_flow = 1'b0;
   int        hold_requests = 0;
   int        holds_served = 0;
   int        hold_left = 0;
   logic      [15:0] ready_pattern = 16'hFFFF;
   int        pattern_pos = 0;
   int        gap_left = 0;
   int        burst_left = 1;
   logic      req_taken = 1'b0;
   pixel_type next_px;

   int     mismatches = 0;
   int     cycle_count = 0;

   // clock
   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // one window evaluation: classify the center pixel and update the hit count
   function automatic cmf_pkg::result_type judge_pixel(
      input longint l2, input longint l1, input longint c,
      input longint r1, input longint r2, input longint sigma, input bit last);
      cmf_pkg::result_type r;
      longint              resp16;
      bit                  hit;
      resp16 = CENTER_GAIN * c - NEAR_GAIN * (l1 + r1) - (l2 + r2);
      hit = (sigma > 0) && (resp16 * 16 > longint'(clip_now) * sigma);
      if (hit && hit_tally < HIT_CEILING)
         hit_tally++;
      r.is_cosmic = hit;
      r.hit_count = hit_tally[COUNT_BITS-1:0];
      r.last_result = last;
      return r;
   endfunction

   // advance the predicted window by one accepted pixel
   task automatic absorb_pixel(input pixel_type p);
      longint x;
      longint sg;
      x = p.flux;
      sg = p.sigma;
      // first pixel fills the window, giving the left-edge clamp
      if (pixels_in_spec == 0)
         for (int k = 0; k < 4; k++)
            flux_win[k] = x;
      if (pixels_in_spec >= 2)
         predicted_results.push_back(judge_pixel(flux_win[0], flux_win[1], flux_win[2],
                                                 flux_win[3], x, sigma_wait[0], 1'b0));
      flux_win[0] = flux_win[1];
      flux_win[1] = flux_win[2];
      flux_win[2] = flux_win[3];
      flux_win[3] = x;
      sigma_wait[0] = sigma_wait[1];
      sigma_wait[1] = sg;
      if (p.eos) begin
         // flush the tail with the right-edge clamp
         if (pixels_in_spec >= 1)
            predicted_results.push_back(judge_pixel(flux_win[0], flux_win[1], flux_win[2],
                                                    flux_win[3], flux_win[3], sigma_wait[0],
                                                    1'b0));
         predicted_results.push_back(judge_pixel(flux_win[1], flux_win[2], flux_win[3],
                                                 flux_win[3], flux_win[3], sigma_wait[1],
                                                 1'b1));
         for (int k = 0; k < 4; k++)
            flux_win[k] = 0;
         sigma_wait[0] = 0;
         sigma_wait[1] = 0;
         pixels_in_spec = 0;
         hit_tally = 0;
      end else if (pixels_in_spec < 3) begin
         pixels_in_spec++;
      end
   endtask

   task automatic queue_pixel(input int flux, input int sigma, input bit eos);
      pixel_type p;
      p.flux = SAMPLE_BITS'(flux);
      p.sigma = SAMPLE_BITS'(sigma);
      p.eos = eos;
      pending_pixels.push_back(p);
   endtask

   function automatic pixel_type random_pixel(input pixel_kind_type kind);
      pixel_type p;
      int        mag;
      p.flux = SAMPLE_BITS'($urandom);
      p.sigma = SAMPLE_BITS'($urandom);
      p.eos = 1'b0;
      case (kind)
         PIX_BACKGROUND: begin
            p.flux = SAMPLE_BITS'(int'($urandom_range(0, 100)) - 50);
            p.sigma = SAMPLE_BITS'($urandom_range(1, 200));
         end
         PIX_SPIKE: begin
            mag = $urandom_range(2000, (1 << (SAMPLE_BITS - 1)) - 1);
            p.flux = SAMPLE_BITS'($urandom_range(0, 3) == 0 ? -mag : mag);
            p.sigma = SAMPLE_BITS'($urandom_range(1, 200));
         end
         PIX_DEAD_SIGMA: begin
            p.sigma = $urandom_range(0, 1) ? '0 : -SAMPLE_BITS'($urandom_range(1, 8388608));
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // random spectra, each closed by an end-of-spectrum pixel
   task automatic queue_random_spectra(input int n_pixels);
      int             sent;
      int             len;
      int             pick;
      pixel_type      p;
      pixel_kind_type kind;
      sent = 0;
      while (sent < n_pixels) begin
         pick = $urandom_range(0, 9);
         len = (pick < 7) ? $urandom_range(3, 8) :
               (pick < 9) ? $urandom_range(9, 20) : $urandom_range(1, 2);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 19);
            kind = (pick < 3) ? PIX_WILD : (pick < 12) ? PIX_BACKGROUND :
                   (pick < 17) ? PIX_SPIKE : PIX_DEAD_SIGMA;
            p = random_pixel(kind);
            p.eos = (i == len - 1);
            pending_pixels.push_back(p);
         end
         sent += len;
      end
   endtask

   // sequence waits until every pixel is sent and every predicted result delivered
   task automatic drain_block();
      while (pending_pixels.size() != 0 || req_bus.valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clip(input logic [cmf_pkg::CLIP_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.clip_factor <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // stimulus sequence
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.flux_sample = '0;
      req_bus.sigma_sample = '0;
      req_bus.end_of_spectrum = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.clip_factor = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed spectra at the reset threshold
      queue_pixel(8388607, 1, 1'b1);
      queue_pixel(-8388608, 8388607, 1'b0);
      queue_pixel(8388607, -8388608, 1'b1);
      queue_pixel(0, 0, 1'b0);
      queue_pixel(8388607, 0, 1'b0);
      queue_pixel(0, 0, 1'b1);
      queue_pixel(0, 1, 1'b0);
      queue_pixel(0, 1, 1'b0);
      queue_pixel(1000, 1, 1'b0);
      queue_pixel(0, 1, 1'b0);
      queue_pixel(0, 1, 1'b1);
      queue_pixel(0, 1, 1'b0);
      queue_pixel(5000, -5, 1'b0);
      queue_pixel(0, 1, 1'b1);
      queue_pixel(8388607, 8388607, 1'b0);
      queue_pixel(-8388608, 1, 1'b0);
      queue_pixel(8388607, 1, 1'b0);
      queue_pixel(-8388608, 8388607, 1'b0);
      queue_pixel(8388607, 1, 1'b1);
      queue_pixel(10, 2, 1'b0);
      queue_pixel(-10, 2, 1'b0);
      queue_pixel(20, 2, 1'b0);
      queue_pixel(5, 3, 1'b1);
      drain_block();

      // zero threshold, with a long receiver hold-off while pixels keep coming
      write_clip('0);
      hold_requests++;
      queue_random_spectra(25);
      drain_block();

      // largest threshold with no idling on either side
      write_clip('1);
      steady_flow = 1'b1;
      queue_random_spectra(25);
      drain_block();
      steady_flow = 1'b0;

      write_clip(cmf_pkg::CLIP_BITS'($urandom));
      queue_random_spectra(25);
      drain_block();

      write_clip(16'd256);
      hold_requests++;
      queue_random_spectra(25);
      drain_block();

      if (mismatches == 0 && predicted_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // sample driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (!steady_flow && gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            next_px = pending_pixels.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.flux_sample <= next_px.flux;
            req_bus.sigma_sample <= next_px.sigma;
            req_bus.end_of_spectrum <= next_px.eos;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver: rotating stall pattern plus requested long hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (steady_flow) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         pattern_pos++;
         if (pattern_pos == 16) begin
            pattern_pos = 0;
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                            16'($urandom | $urandom);
         end
      end
   end

   // monitor: track register writes, predict on accepted pixels, check results
   always @(posedge clock) begin
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            clip_now = csr_bus.clip_factor;
         if (req_bus.valid && req_bus.ready)
            absorb_pixel('{req_bus.flux_sample, req_bus.sigma_sample,
                           req_bus.end_of_spectrum});
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected result transaction %s=%0b hit_count=%0d last=%0b",
                           $time, "is_cosmic", rsp_bus.is_cosmic, rsp_bus.hit_count,
                           rsp_bus.last_result);
            end else begin
               cmf_pkg::result_type want;
               want = predicted_results.pop_front();
               if (rsp_bus.is_cosmic !== want.is_cosmic ||
                   rsp_bus.hit_count !== want.hit_count ||
                   rsp_bus.last_result !== want.last_result) begin
                  mismatches++;
                  // keep the log readable when a whole spectrum goes wrong
                  if (mismatches <= MAX_REPORTS)
                     $display({"%0t: mismatch expected is_cosmic=%0b hit_count=%0d last=%0b,",
                               " got is_cosmic=%0b hit_count=%0d last=%0b"},
                              $time, want.is_cosmic, want.hit_count, want.last_result,
                              rsp_bus.is_cosmic, rsp_bus.hit_count, rsp_bus.last_result);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
